@@ hdl/dbl_pkg.sv @@
// Package for the debouncer with long-state detection.
// Holds the register widths, register indexes, reset values and shared structs.
// Depends on nothing.
`default_nettype none

package dbl_pkg;

	localparam int unsigned TIME_W    = 32;
	localparam int unsigned CFG_IDX_W = 1;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MS     = 1'd1;

	localparam logic [TIME_W-1:0] DEBOUNCE_MS_RST = 32'd50;
	localparam logic [TIME_W-1:0] LONG_MS_RST     = 32'd1000;

	typedef struct packed {
		logic [TIME_W-1:0] debounce_ms;
		logic [TIME_W-1:0] long_ms;
	} dbl_cfg_t;

	typedef struct packed {
		logic level_high;
		logic rose;
		logic fell;
		logic rose_long;
		logic fell_long;
	} dbl_result_t;

endpackage

`default_nettype wire

@@ hdl/dbl_cfg.sv @@
// Configuration registers of the debouncer: debounce and long-state times.
// Depends on dbl_pkg.
`default_nettype none

module dbl_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [dbl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dbl_pkg::TIME_W-1:0]      cfg_data,
	output dbl_pkg::dbl_cfg_t                    cfg
);

	dbl_pkg::dbl_cfg_t cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= dbl_pkg::DEBOUNCE_MS_RST;
			cfg_q.long_ms     <= dbl_pkg::LONG_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dbl_pkg::REG_DEBOUNCE_MS: cfg_q.debounce_ms <= cfg_data;
				dbl_pkg::REG_LONG_MS:     cfg_q.long_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hdl/dbl_core.sv @@
// Debounce state and per-beat step logic: level, last sample and the two timers.
// Produces the result of one beat combinationally; state moves on step.
// Depends on dbl_pkg.
`default_nettype none

module dbl_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic                        pin,
	input  wire logic [dbl_pkg::TIME_W-1:0]  now,
	input  wire dbl_pkg::dbl_cfg_t           cfg,
	output dbl_pkg::dbl_result_t             res
);

	logic                       level_q;
	logic                       last_q;
	logic                       db_active_q;
	logic [dbl_pkg::TIME_W-1:0] db_start_q;
	logic                       long_active_q;
	logic [dbl_pkg::TIME_W-1:0] long_start_q;

	logic                       db_running;
	logic                       restart;
	logic                       flip;
	logic                       long_running;
	logic                       long_expired;
	logic [dbl_pkg::TIME_W-1:0] db_elapsed;
	logic [dbl_pkg::TIME_W-1:0] long_elapsed;

	// debounce timer: expiry, then restart on a fresh edge toward the level
	always_comb begin
		db_elapsed = now - db_start_q;
		db_running = db_active_q && (db_elapsed < cfg.debounce_ms);
		restart    = db_running && (level_q ? (!last_q && pin) : (last_q && !pin));
		flip       = !db_running && (pin != level_q);
	end

	// long timer: a flip restarts it at now, so elapsed is zero then
	always_comb begin
		long_elapsed = flip ? '0 : (now - long_start_q);
		long_running = flip || long_active_q;
		long_expired = long_running && (long_elapsed >= cfg.long_ms);
	end

	// result of this beat
	always_comb begin
		res.level_high = flip ? pin : level_q;
		res.rose       = flip && pin;
		res.fell       = flip && !pin;
		res.rose_long  = long_expired && res.level_high;
		res.fell_long  = long_expired && !res.level_high;
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q       <= 1'b0;
			last_q        <= 1'b0;
			db_active_q   <= 1'b0;
			db_start_q    <= '0;
			long_active_q <= 1'b0;
			long_start_q  <= '0;
		end else if (step) begin
			level_q       <= res.level_high;
			last_q        <= pin;
			db_active_q   <= db_running || flip;
			long_active_q <= long_running && !long_expired;
			if (restart || flip) begin
				db_start_q <= now;
			end
			if (flip) begin
				long_start_q <= now;
			end
		end
	end

	// checks
	a_no_rise_and_fall: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !(res.rose && res.fell))
		else $error("rise and fall in one beat");

	a_flip_arms_debounce: assert property (@(posedge clk) disable iff (!arst_n)
		step && flip |=> db_active_q && (db_start_q == $past(now)))
		else $error("debounce timer not armed after a level change");

	a_long_pulse_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && (res.rose_long || res.fell_long) |=> !long_active_q)
		else $error("long timer still running after its pulse");

	a_long_follows_level: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.rose_long |=> level_q)
		else $error("long-high pulse without a high level");

endmodule

`default_nettype wire

@@ hdl/debounced_input_with_long_state.sv @@
// Switch debouncer with long-state detection. Each input beat carries a raw pin
// sample and a free-running 32-bit millisecond timestamp; each yields exactly one
// result beat with the debounced level and rise, fall, long-high and long-low
// pulses. One beat is taken every clock cycle while in_stall is low; a result
// passes through the input register, then the result register, and the step
// logic updates the state from the input register as each beat advances.
// Depends on dbl_pkg, dbl_cfg and dbl_core.
`default_nettype none

module debounced_input_with_long_state (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_we,
	input  wire logic [dbl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dbl_pkg::TIME_W-1:0]      cfg_data,
	// input beats
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            pin_level,
	input  wire logic [dbl_pkg::TIME_W-1:0]      now_ms,
	// result beats
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 level_high,
	output logic                                 rose,
	output logic                                 fell,
	output logic                                 rose_long,
	output logic                                 fell_long
);

	dbl_pkg::dbl_cfg_t    cfg;
	dbl_pkg::dbl_result_t res;
	dbl_pkg::dbl_result_t res_q;

	logic                       valid_s1;
	logic                       pin_s1;
	logic [dbl_pkg::TIME_W-1:0] now_s1;
	logic                       out_valid_q;
	logic                       advance;
	logic                       in_take;

	dbl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1 moves to the result register whenever that is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || advance) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pin_s1 <= pin_level;
			now_s1 <= now_ms;
		end
	end

	dbl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.pin    (pin_s1),
		.now    (now_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign level_high = res_q.level_high;
	assign rose       = res_q.rose;
	assign fell       = res_q.fell;
	assign rose_long  = res_q.rose_long;
	assign fell_long  = res_q.fell_long;

	// checks
	a_no_loss_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("result beat dropped under stall");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(now_s1) && $stable(pin_s1))
		else $error("input stage lost a beat");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced beat missing from result register");

endmodule

`default_nettype wire
